FILE: sv/ntc_pkg.sv
package ntc_pkg;

   typedef enum logic [1:0] {
      CSR_PULLUP  = 2'd0,
      CSR_NOMINAL = 2'd1,
      CSR_BETA    = 2'd2,
      CSR_REF     = 2'd3
   } csr_index_type;

   localparam logic [19:0] PULLUP_RESET  = 20'd20000;
   localparam logic [19:0] NOMINAL_RESET = 20'd10000;
   localparam logic [13:0] BETA_RESET    = 14'd3380;
   localparam logic [15:0] REF_RESET     = 16'd29815;

   // round(ln2 * 2^30)
   localparam logic [29:0] LN2_Q30 = 30'd744261118;
   localparam int          FRAC_BITS = 24;
   // normalize + squarings + multiply + round
   localparam int          LN_LAT = FRAC_BITS + 3;
   localparam int          LN_W = 29;

   localparam int          DEN_W = 50;
   localparam int          A_W = 49;
   localparam int          NUM_W = 61;
   localparam int          DVD_W = 62;
   localparam int          Q_W = 17;
   localparam int          CMP_W = A_W + Q_W;
   localparam int          DIV_STAGES = Q_W + 1;
   // ln, sum, products, den/num, abs, dividend, divider, final
   localparam int          BACK_LAT = LN_LAT + 5 + DIV_STAGES + 1;

   localparam logic [15:0] ZERO_C_CENTI = 16'd27315;
   localparam logic [Q_W-1:0] Q_MAX_POS = 17'd60082;
   localparam logic [Q_W-1:0] Q_MAX_NEG = 17'd5453;
   localparam logic [15:0] TEMP_MAX = 16'h7fff;
   localparam logic [15:0] TEMP_MIN = 16'h8000;

   typedef struct packed {
      logic [15:0] temp_centi_c;
      logic        valid_res;
      logic        clipped;
   } rsp_type;

   typedef struct packed {
      logic vld;
      logic ok;
   } tag_type;

endpackage

FILE: sv/ntc_fifo.sv
module ntc_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]      cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign empty   = (cnt_ff == '0);
   assign full    = (cnt_ff == (AW+1)'(DEPTH));
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ff];

   always_comb begin
      wr_in  = do_push ? AW'(wr_ff + 1'b1) : wr_ff;
      rd_in  = do_pop ? AW'(rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= wdata;
      end
   end
endmodule

FILE: sv/ntc_front.sv
module ntc_front #(
   parameter int ADC_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  logic [ADC_BITS-1:0]   raw,
   output logic                  full,
   input  logic                  mid_full,
   output logic                  mid_push,
   output logic [2*ADC_BITS+2:0] mid_data
);
   localparam int NW = ADC_BITS + 1;
   localparam logic [NW+1:0] FS3 = (NW+2)'(3) << (ADC_BITS - 1);

   logic              vld_ff;
   logic              ok_ff, ok_in;
   logic [NW-1:0]     n_ff, n_in, d_ff, d_in;
   logic [NW+1:0]     ext, n5;

   // classify: ratio strictly inside (0,1)
   always_comb begin
      ext   = {{3{raw[ADC_BITS-1]}}, raw};
      n5    = ext + (ext << 2);
      ok_in = !raw[ADC_BITS-1] && (raw != '0) && (n5 < FS3);
      n_in  = n5[NW-1:0];
      d_in  = NW'(FS3 - n5);
   end

   assign full     = vld_ff && mid_full;
   assign mid_push = vld_ff && !mid_full;
   assign mid_data = {ok_ff, n_ff, d_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (!full) begin
         vld_ff <= push;
      end
   end

   always_ff @(posedge clock) begin
      if (push && !full) begin
         ok_ff <= ok_in;
         n_ff  <= n_in;
         d_ff  <= d_in;
      end
   end
endmodule

FILE: sv/ntc_ln.sv
module ntc_ln (
   input  logic                     clock,
   input  logic                     en,
   input  logic [31:0]              v,
   output logic [ntc_pkg::LN_W-1:0] ln_q24
);
   localparam int FB = ntc_pkg::FRAC_BITS;

   logic [30:0]   y_ff  [FB+1];
   logic [4:0]    k_ff  [FB+1];
   logic [FB-1:0] fr_ff [FB+1];
   logic [4:0]    kk;
   logic [62:0]   sh;
   logic [30:0]   y0;
   logic [58:0]   prod_ff;
   logic [59:0]   rnd;
   logic [ntc_pkg::LN_W-1:0] ln_ff;

   // top set bit and mantissa in Q30
   always_comb begin
      kk = '0;
      for (int i = 0; i < 32; i++) begin
         if (v[i]) begin
            kk = 5'(i);
         end
      end
      sh = {31'b0, v} << (5'd30 - kk);
      y0 = (kk == 5'd31) ? v[31:1] : sh[30:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         y_ff[0]  <= y0;
         k_ff[0]  <= kk;
         fr_ff[0] <= '0;
      end
   end

   for (genvar s = 1; s <= FB; s++) begin : g_sq
      logic [61:0] sq;
      logic [31:0] t;
      assign sq = y_ff[s-1] * y_ff[s-1];
      assign t  = sq[61:30];
      always_ff @(posedge clock) begin
         if (en) begin
            y_ff[s]  <= t[31] ? t[31:1] : t[30:0];
            fr_ff[s] <= {fr_ff[s-1][FB-2:0], t[31]};
            k_ff[s]  <= k_ff[s-1];
         end
      end
   end

   assign rnd = {1'b0, prod_ff} + (60'd1 << 29);

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= {k_ff[FB], fr_ff[FB]} * ntc_pkg::LN2_Q30;
         ln_ff   <= rnd[30+ntc_pkg::LN_W-1:30];
      end
   end

   assign ln_q24 = ln_ff;
endmodule

FILE: sv/ntc_back.sv
module ntc_back #(
   parameter int ADC_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_vld,
   input  logic [2*ADC_BITS+2:0] in_data,
   input  logic [19:0]           pu_ohms,
   input  logic [19:0]           nominal,
   input  logic [13:0]           beta,
   input  logic [15:0]           tc,
   output logic                  out_vld,
   output ntc_pkg::rsp_type      out_rsp
);
   localparam int NW  = ADC_BITS + 1;
   localparam int LAT = ntc_pkg::BACK_LAT;
   localparam int LW  = ntc_pkg::LN_W;
   localparam int AW  = ntc_pkg::A_W;
   localparam int DW  = ntc_pkg::DVD_W;
   localparam int QW  = ntc_pkg::Q_W;
   localparam int CW  = ntc_pkg::CMP_W;
   localparam int DS  = ntc_pkg::DIV_STAGES;

   ntc_pkg::tag_type tag_ff [LAT];
   ntc_pkg::tag_type tag_in;

   logic [NW-1:0] n, d;
   logic [LW-1:0] l_pu, l_n, l_nom, l_d;

   logic [31:0]               lsum_ff;
   logic signed [48:0]        prod_ff;
   logic [29:0]               tb_ff;
   logic [20:0]               b100_ff;
   logic signed [ntc_pkg::DEN_W-1:0] den_ff;
   logic [ntc_pkg::NUM_W-1:0] num_ff, num4_ff;
   logic [AW-1:0]             a4_ff, a5_ff;
   logic                      neg4_ff, dz4_ff, neg5_ff, dz5_ff;
   logic [DW-1:0]             dvd_ff;
   logic [36:0]               tb100;

   logic [DW-1:0] rem_ff [DS];
   logic [AW-1:0] ad_ff  [DS];
   logic [QW-1:0] q_ff   [DS];
   logic          ovf_ff [DS];
   logic          neg_ff [DS];
   logic          dz_ff  [DS];

   ntc_pkg::rsp_type rsp_ff, rsp_in;
   logic [QW-1:0]    qf;
   logic [17:0]      tpos, tneg;
   logic             zero_reg;

   assign n = in_data[2*NW-1:NW];
   assign d = in_data[NW-1:0];

   ntc_ln u_ln_pu (.clock(clock), .en(en), .v(32'(pu_ohms)), .ln_q24(l_pu));
   ntc_ln u_ln_n (.clock(clock), .en(en), .v(32'(n)), .ln_q24(l_n));
   ntc_ln u_ln_nom (.clock(clock), .en(en), .v(32'(nominal)), .ln_q24(l_nom));
   ntc_ln u_ln_d (.clock(clock), .en(en), .v(32'(d)), .ln_q24(l_d));

   assign tag_in.vld = in_vld;
   assign tag_in.ok  = in_data[2*NW];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < LAT; j++) begin
            tag_ff[j] <= '0;
         end
      end else if (en) begin
         tag_ff[0] <= tag_in;
         for (int j = 1; j < LAT; j++) begin
            tag_ff[j] <= tag_ff[j-1];
         end
      end
   end

   assign tb100 = 37'(tb_ff) * 37'd100;

   always_ff @(posedge clock) begin
      if (en) begin
         lsum_ff <= 32'(l_pu) + 32'(l_n) - 32'(l_nom) - 32'(l_d);
         prod_ff <= $signed(lsum_ff) * $signed({1'b0, tc});
         tb_ff   <= tc * beta;
         b100_ff <= beta * 7'd100;
         den_ff  <= $signed({5'b0, b100_ff, 24'b0}) + ntc_pkg::DEN_W'(prod_ff);
         num_ff  <= {tb100, 24'b0};
         neg4_ff <= den_ff[ntc_pkg::DEN_W-1];
         dz4_ff  <= (den_ff == '0);
         a4_ff   <= den_ff[ntc_pkg::DEN_W-1] ? AW'(-den_ff) : AW'(den_ff);
         num4_ff <= num_ff;
         dvd_ff  <= DW'(num4_ff) + DW'(a4_ff >> 1);
         a5_ff   <= a4_ff;
         neg5_ff <= neg4_ff;
         dz5_ff  <= dz4_ff;
      end
   end

   // quotient overflow check, then one quotient bit per stage
   always_ff @(posedge clock) begin
      if (en) begin
         ovf_ff[0] <= CW'(dvd_ff) >= {a5_ff, QW'(0)};
         rem_ff[0] <= dvd_ff;
         ad_ff[0]  <= a5_ff;
         q_ff[0]   <= '0;
         neg_ff[0] <= neg5_ff;
         dz_ff[0]  <= dz5_ff;
      end
   end

   for (genvar s = 1; s < DS; s++) begin : g_div
      logic [CW-1:0] sh;
      logic          ge;
      assign sh = CW'(ad_ff[s-1]) << (QW - s);
      assign ge = CW'(rem_ff[s-1]) >= sh;
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s] <= ge ? DW'(rem_ff[s-1] - sh[DW-1:0]) : rem_ff[s-1];
            q_ff[s]   <= q_ff[s-1] | (ge ? (QW'(1) << (QW - s)) : QW'(0));
            ad_ff[s]  <= ad_ff[s-1];
            ovf_ff[s] <= ovf_ff[s-1];
            neg_ff[s] <= neg_ff[s-1];
            dz_ff[s]  <= dz_ff[s-1];
         end
      end
   end

   always_comb begin
      qf       = q_ff[DS-1];
      tpos     = {1'b0, qf} - {2'b0, ntc_pkg::ZERO_C_CENTI};
      tneg     = 18'(0) - {1'b0, qf} - {2'b0, ntc_pkg::ZERO_C_CENTI};
      zero_reg = (pu_ohms == '0) || (nominal == '0) || (beta == '0) || (tc == '0);
      rsp_in   = '0;
      if (!tag_ff[LAT-2].ok) begin
         rsp_in = '0;
      end else if (zero_reg) begin
         rsp_in.valid_res    = 1'b1;
         rsp_in.temp_centi_c = 16'(0) - ntc_pkg::ZERO_C_CENTI;
      end else begin
         rsp_in.valid_res = 1'b1;
         if (dz_ff[DS-1]) begin
            rsp_in.temp_centi_c = ntc_pkg::TEMP_MAX;
            rsp_in.clipped      = 1'b1;
         end else if (!neg_ff[DS-1]) begin
            if (ovf_ff[DS-1] || (qf > ntc_pkg::Q_MAX_POS)) begin
               rsp_in.temp_centi_c = ntc_pkg::TEMP_MAX;
               rsp_in.clipped      = 1'b1;
            end else begin
               rsp_in.temp_centi_c = tpos[15:0];
            end
         end else begin
            if (ovf_ff[DS-1] || (qf > ntc_pkg::Q_MAX_NEG)) begin
               rsp_in.temp_centi_c = ntc_pkg::TEMP_MIN;
               rsp_in.clipped      = 1'b1;
            end else begin
               rsp_in.temp_centi_c = tneg[15:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign out_vld = tag_ff[LAT-1].vld;
   assign out_rsp = rsp_ff;
endmodule

FILE: sv/ntc_thermistor_to_temperature.sv
// NTC thermistor divider reading to temperature in 0.01 degC (Beta equation)
// input queue: drive req_raw_counts with push; a transfer happens when push
//   is high and full is low
// result queue: while empty is low the oldest result sits on rsp_*; pop
//   takes it at a clock edge with empty low
// csr port: csr_index / csr_wdata with csr_valid; csr_ready is always high,
//   write only while no item is in flight
// throughput: one item per cycle while the result queue is not full; the
//   four log units and the 17-bit restoring divider are fully pipelined
// path: a push transfer passes the classify register, the 4-entry queue,
//   the conversion pipeline and the result queue before empty goes low
// when pop is held low the result queue fills and the conversion pipeline
//   freezes as a whole; the 4-entry queue behind the classifier keeps
//   taking items until it is full, then full rises
// reset: synchronous, clears both queues and the pipeline valids, loads
//   the default pullup, nominal, beta and reference values
module ntc_thermistor_to_temperature #(
   parameter int ADC_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   output logic                full,
   input  logic [ADC_BITS-1:0] req_raw_counts,
   output logic                empty,
   input  logic                pop,
   output logic [15:0]         rsp_temp_centi_c,
   output logic                rsp_valid_res,
   output logic                rsp_clipped,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [1:0]          csr_index,
   input  logic [19:0]         csr_wdata
);
   localparam int MW = 2 * ADC_BITS + 3;

   logic [19:0] pullup_ff, nominal_ff;
   logic [13:0] beta_ff;
   logic [15:0] ref_ff;

   logic          mid_push, mid_full, mid_empty, mid_pop, en;
   logic [MW-1:0] front_data, mid_data;
   logic          back_vld, out_full;
   ntc_pkg::rsp_type back_rsp, out_rsp;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pullup_ff  <= ntc_pkg::PULLUP_RESET;
         nominal_ff <= ntc_pkg::NOMINAL_RESET;
         beta_ff    <= ntc_pkg::BETA_RESET;
         ref_ff     <= ntc_pkg::REF_RESET;
      end else if (csr_valid) begin
         case (ntc_pkg::csr_index_type'(csr_index))
            ntc_pkg::CSR_PULLUP:  pullup_ff  <= csr_wdata;
            ntc_pkg::CSR_NOMINAL: nominal_ff <= csr_wdata;
            ntc_pkg::CSR_BETA:    beta_ff    <= csr_wdata[13:0];
            ntc_pkg::CSR_REF:     ref_ff     <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   ntc_front #(.ADC_BITS(ADC_BITS)) u_front (
      .clock(clock), .reset(reset), .push(push), .raw(req_raw_counts),
      .full(full), .mid_full(mid_full), .mid_push(mid_push), .mid_data(front_data)
   );

   ntc_fifo #(.WIDTH(MW), .DEPTH(4)) u_mid_q (
      .clock(clock), .reset(reset), .push(mid_push), .wdata(front_data),
      .full(mid_full), .pop(mid_pop), .rdata(mid_data), .empty(mid_empty)
   );

   assign en      = !out_full;
   assign mid_pop = en && !mid_empty;

   ntc_back #(.ADC_BITS(ADC_BITS)) u_back (
      .clock(clock), .reset(reset), .en(en), .in_vld(mid_pop), .in_data(mid_data),
      .pu_ohms(pullup_ff), .nominal(nominal_ff), .beta(beta_ff), .tc(ref_ff),
      .out_vld(back_vld), .out_rsp(back_rsp)
   );

   ntc_fifo #(.WIDTH($bits(ntc_pkg::rsp_type)), .DEPTH(2)) u_out_q (
      .clock(clock), .reset(reset), .push(back_vld && en), .wdata(back_rsp),
      .full(out_full), .pop(pop), .rdata(out_rsp), .empty(empty)
   );

   assign rsp_temp_centi_c = out_rsp.temp_centi_c;
   assign rsp_valid_res    = out_rsp.valid_res;
   assign rsp_clipped      = out_rsp.clipped;
endmodule

FILE: sv/ntc_checker.sv
module ntc_checker (
   input logic        clock,
   input logic        reset,
   input logic        full,
   input logic        empty,
   input logic [15:0] rsp_temp_centi_c,
   input logic        rsp_valid_res,
   input logic        rsp_clipped
);
   a_reset_empty: assert property (@(posedge clock) reset |=> empty)
      else $error("result queue not empty after reset");

   a_reset_not_full: assert property (@(posedge clock) reset |=> !full)
      else $error("input queue full after reset");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_valid_res) |-> (rsp_temp_centi_c == 16'h0000 && !rsp_clipped))
      else $error("invalid result carries data");

   a_clip_limit: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_clipped) |->
         (rsp_temp_centi_c == 16'h7fff || rsp_temp_centi_c == 16'h8000))
      else $error("clipped result not at a limit");
endmodule

bind ntc_thermistor_to_temperature ntc_checker u_ntc_checker (
   .clock(clock), .reset(reset), .full(full), .empty(empty),
   .rsp_temp_centi_c(rsp_temp_centi_c), .rsp_valid_res(rsp_valid_res),
   .rsp_clipped(rsp_clipped)
);
